@@ rtl/core/utf8cc_pkg.sv @@
// Shared types, constants and byte classification for the UTF-8 character counter.
`default_nettype none

package utf8cc_pkg;

    localparam int unsigned RES_COUNT_W = 16;
    localparam int unsigned OUT_DATA_W  = 24;

    // Continuation counts; LEAD_BAD marks a byte that cannot start a character
    localparam logic [2:0] LEAD_BAD = 3'd6;

    localparam logic [1:0] BOM_DONE = 2'd3;

    localparam logic [7:0] BOM_BYTE0 = 8'hEF;
    localparam logic [7:0] BOM_BYTE1 = 8'hBB;
    localparam logic [7:0] BOM_BYTE2 = 8'hBF;

    // Decode state carried between bytes of one string
    typedef struct packed {
        logic [2:0] cont_left;
        logic       err;
        logic [1:0] bom_step;
        logic       bom_poss;
    } dec_state_t;

    localparam dec_state_t DEC_RESET = '{cont_left: 3'd0, err: 1'b0,
                                         bom_step: 2'd0, bom_poss: 1'b1};

    // Result flags from the decoder for the word that closes a string
    typedef struct packed {
        logic inc;
        logic res_err;
        logic res_bom;
    } dec_flags_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] n;
        begin
            case (b) inside
                8'b0???????: n = 3'd0;
                8'b110?????: n = 3'd1;
                8'b1110????: n = 3'd2;
                8'b11110???: n = 3'd3;
                8'b111110??: n = 3'd4;
                8'b1111110?: n = 3'd5;
                default:     n = LEAD_BAD;
            endcase
            return n;
        end
    endfunction

    function automatic logic [7:0] bom_byte(input logic [1:0] step);
        logic [7:0] v;
        begin
            case (step)
                2'd0:    v = BOM_BYTE0;
                2'd1:    v = BOM_BYTE1;
                default: v = BOM_BYTE2;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/utf8cc_decode.sv @@
// Combinational next-state logic for one byte: BOM match, lead and continuation checks.
`default_nettype none

module utf8cc_decode
(
    input  wire logic [7:0]            data_byte,
    input  wire logic                  last_byte,
    input  wire utf8cc_pkg::dec_state_t cur,
    output utf8cc_pkg::dec_state_t     nxt,
    output utf8cc_pkg::dec_flags_t     flags
);
    import utf8cc_pkg::*;

    dec_state_t upd;
    logic       bom_done_now;
    logic [2:0] lead_n;

    assign lead_n = lead_length(data_byte);

    always_comb
    begin
        upd          = cur;
        bom_done_now = 1'b0;
        flags.inc    = 1'b0;

        if (cur.bom_poss && (cur.bom_step != BOM_DONE))
        begin
            if (data_byte == bom_byte(cur.bom_step))
            begin
                upd.bom_step = cur.bom_step + 2'd1;
                bom_done_now = (cur.bom_step == 2'd2);
            end
            else
            begin
                upd.bom_poss = 1'b0;
            end
        end

        if (!cur.err)
        begin
            if (cur.cont_left == 3'd0)
            begin
                if (lead_n == LEAD_BAD)
                    upd.err = 1'b1;
                else if (lead_n == 3'd0)
                    flags.inc = 1'b1;
                else
                    upd.cont_left = lead_n;
            end
            else if (data_byte[7:6] != 2'b10)
            begin
                upd.err = 1'b1;
            end
            else
            begin
                upd.cont_left = cur.cont_left - 3'd1;
                // the BOM itself is not a character
                if ((cur.cont_left == 3'd1) && !bom_done_now)
                    flags.inc = 1'b1;
            end
        end

        // flag an invalid byte or a truncated sequence at end of string
        flags.res_err = upd.err | (upd.cont_left != 3'd0);
        flags.res_bom = upd.bom_poss && (upd.bom_step == BOM_DONE);

        nxt = last_byte ? DEC_RESET : upd;
    end

endmodule

`default_nettype wire

@@ rtl/core/utf8cc_count.sv @@
// Saturating character counter with clear at end of string and 16-bit result view.
`default_nettype none

module utf8cc_count
#(
    parameter int unsigned COUNT_BITS = 16
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               inc,
    input  wire logic                               clr,
    output logic [utf8cc_pkg::RES_COUNT_W-1:0]      res_count
);
    import utf8cc_pkg::*;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    assign count_next = (inc && (count_reg != {COUNT_BITS{1'b1}})) ?
                        count_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1} : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (en)
            count_reg <= clr ? '0 : count_next;
    end

    // clamp or zero-extend to the result field width
    generate
        if (COUNT_BITS > RES_COUNT_W)
        begin : g_clamp
            assign res_count = (count_next[COUNT_BITS-1:RES_COUNT_W] != '0) ?
                               {RES_COUNT_W{1'b1}} : count_next[RES_COUNT_W-1:0];
        end
        else
        begin : g_extend
            assign res_count = RES_COUNT_W'(count_next);
        end
    endgenerate

endmodule

`default_nettype wire

@@ rtl/core/utf8_char_counter.sv @@
// Top level of the UTF-8 character counter: decode state, counter and result register.
//
//  channel  | dir | handshake        | contents
//  ---------+-----+------------------+---------------------------------------------
//  s_*      | in  | s_tvalid/s_tready| s_tdata = data_byte, s_tlast = last_byte
//  m_*      | out | m_tvalid/m_tready| m_tdata = char_count, stopped_on_error,
//           |     |                  |           bom_present (one word per string)
//
// One byte is taken per cycle while s_tready is high; the decode and count update
// lie between state and result registers; the result shows the cycle after s_tlast.
// Reset clears the decode state, the counter and the result valid flag.
// s_tready drops only while a result is held and m_tready is low; bytes that do
// not close a string still wait for that result to leave.
`default_nettype none

module utf8_char_counter
#(
    parameter int unsigned COUNT_BITS = 16
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [7:0] data_byte
    input  wire logic                               s_tlast,   // last_byte
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [15:0] char_count, [16] stopped_on_error, [17] bom_present, [23:18] zero
    output logic [utf8cc_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import utf8cc_pkg::*;

    dec_state_t             dec_reg;
    dec_state_t             dec_next;
    dec_flags_t             flags;
    logic                   accept;
    logic [RES_COUNT_W-1:0] res_count;
    logic                   res_valid_reg;
    logic [OUT_DATA_W-1:0]  res_data_reg;

    assign s_tready = !res_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    utf8cc_decode u_decode
    (
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .cur       (dec_reg),
        .nxt       (dec_next),
        .flags     (flags)
    );

    utf8cc_count #(.COUNT_BITS(COUNT_BITS)) u_count
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (accept),
        .inc       (flags.inc),
        .clr       (s_tlast),
        .res_count (res_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dec_reg <= DEC_RESET;
        else if (accept)
            dec_reg <= dec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept && s_tlast)
            res_valid_reg <= 1'b1;
        else if (m_tready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_tlast)
            res_data_reg <= {{(OUT_DATA_W-RES_COUNT_W-2){1'b0}},
                             flags.res_bom, flags.res_err, res_count};
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = res_data_reg;

endmodule

`default_nettype wire
